### rtl/bce_pkg.sv
// Package of shared types and constants for the button click event detector.
`default_nettype none

package bce_pkg;

   localparam int NUM_KEYS = 8;
   localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam logic [15:0] TICK_MAX    = 16'hFFFF;
   localparam logic [2:0]  DEBOUNCE_MAX = 3'd7;
   localparam logic [3:0]  REPEAT_MAX  = 4'd15;

   localparam logic [7:0]  MASK_RESET     = 8'd0;
   localparam logic [2:0]  DEBOUNCE_RESET = 3'd3;
   localparam logic [15:0] SHORT_RESET    = 16'd60;
   localparam logic [15:0] LONG_RESET     = 16'd200;

   typedef enum logic [1:0] {
      CSR_ACTIVE_MASK = 2'd0,
      CSR_DEBOUNCE    = 2'd1,
      CSR_SHORT       = 2'd2,
      CSR_LONG        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DOWN   = 3'd1,
      PH_UP     = 3'd2,
      PH_REPEAT = 3'd3,
      PH_LONG   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DOWN   = 3'd1,
      EV_UP     = 3'd2,
      EV_SINGLE = 3'd3,
      EV_LSTART = 3'd4,
      EV_LHOLD  = 3'd5
   } event_type;

   typedef struct packed {
      logic        stable_level;
      logic [2:0]  debounce_count;
      phase_type   phase;
      logic [15:0] tick_count;
      logic [3:0]  press_repeats;
      event_type   last_event;
   } key_state_type;

   // With the reset mask every key rests at level one when released.
   localparam key_state_type KEY_STATE_RESET = '{
      stable_level:   ~MASK_RESET[0],
      debounce_count: 3'd0,
      phase:          PH_IDLE,
      tick_count:     16'd0,
      press_repeats:  4'd0,
      last_event:     EV_NONE
   };

   localparam int STATE_W = $bits(key_state_type);

endpackage

`default_nettype wire

### rtl/bce_req_if.sv
// Request channel interface: one tick sample of one key.
`default_nettype none

interface bce_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] key_index;
   logic       raw_level;

   modport source (output valid, output key_index, output raw_level, input ready);
   modport sink   (input valid, input key_index, input raw_level, output ready);
endinterface

`default_nettype wire

### rtl/bce_rsp_if.sv
// Response channel interface: the event word for one key sample.
`default_nettype none

interface bce_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] key_id;
   logic [2:0] event_code;
   logic [3:0] repeat_count;
   logic       fired_down;
   logic       fired_up;
   logic       fired_repeat;
   logic       fired_single;
   logic       fired_long_start;
   logic       fired_long_hold;

   modport source (
      output valid, output key_id, output event_code, output repeat_count,
      output fired_down, output fired_up, output fired_repeat, output fired_single,
      output fired_long_start, output fired_long_hold, input ready
   );
   modport sink (
      input valid, input key_id, input event_code, input repeat_count,
      input fired_down, input fired_up, input fired_repeat, input fired_single,
      input fired_long_start, input fired_long_hold, output ready
   );
endinterface

`default_nettype wire

### rtl/bce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/button_click_event_detector.sv
// Top level of the per-key button debouncer and click / long-press detector.
//
// Each word on req_ch is one tick sample of one key's raw pin level. For every
// sample accepted, exactly one word leaves on rsp_ch, in order, carrying the key,
// its current event code, its repeat count and one flag per event fired on that
// tick. The per-key state lives in a small RAM: the sample's entry is read as the
// sample is accepted into the update stage, updated there and written back at the
// edge that moves the response word into the output register, which drives
// rsp_ch.valid. A new sample is taken every cycle while the output side does not
// hold the flow back, also for the same key twice running, as the last
// written entry is forwarded to the update.
// The output register parts the two sides: while it holds an untaken word one
// more sample may be accepted and wait in the update stage; only when both are
// full does req_ch.ready drop. The csr_ port writes the four registers at any
// edge with csr_we high outside reset. Reset clears the registers to their
// defaults and marks every key entry as not yet written, which reads as the
// released idle state; no clearing pass is needed.
`default_nettype none

module button_click_event_detector (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bce_req_if.sink                     req_ch,
   bce_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_we,
   input  wire bce_pkg::csr_index_type csr_index,
   input  wire logic [15:0]            csr_wdata
);
   import bce_pkg::*;

   // Configuration registers.
   logic [7:0]  mask_ff;
   logic [2:0]  debounce_ff;
   logic [15:0] short_ff;
   logic [15:0] long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= MASK_RESET;
         debounce_ff <= DEBOUNCE_RESET;
         short_ff    <= SHORT_RESET;
         long_ff     <= LONG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_MASK: mask_ff     <= csr_wdata[7:0];
            CSR_DEBOUNCE:    debounce_ff <= csr_wdata[2:0];
            CSR_SHORT:       short_ff    <= csr_wdata;
            CSR_LONG:        long_ff     <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Update stage and output register control.
   logic              s1_valid_ff;
   logic [2:0]        s1_key_ff;
   logic              s1_pin_ff;
   logic              s1_adv;
   logic              rsp_valid_ff;
   logic [KEY_AW-1:0] s1_addr;
   logic              s1_in_range;

   logic [NUM_KEYS-1:0] written_ff;
   logic                wr_valid_ff;
   logic [KEY_AW-1:0]   wr_addr_ff;
   key_state_type       wr_data_ff;

   logic [KEY_AW-1:0]   rd_addr;
   logic [STATE_W-1:0]  rd_data;
   logic                ram_we;

   key_state_type cur;
   key_state_type nxt;
   logic          act;
   logic          f_down, f_up, f_rep, f_single, f_lstart, f_lhold;

   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign s1_addr      = KEY_AW'(s1_key_ff);
   assign s1_in_range  = (32'(s1_key_ff) < NUM_KEYS);
   assign ram_we       = s1_valid_ff && s1_adv && s1_in_range;

   // A stalled word keeps re-reading its own entry so the RAM output stays current.
   assign rd_addr = (s1_valid_ff && !s1_adv) ? s1_addr : KEY_AW'(req_ch.key_index);

   bce_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_KEYS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr),
      .wr_data (nxt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
         wr_valid_ff  <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s1_valid_ff && s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            written_ff[s1_addr] <= 1'b1;
         end
         wr_valid_ff <= ram_we;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_key_ff <= req_ch.key_index;
         s1_pin_ff <= req_ch.raw_level;
      end
      wr_addr_ff <= s1_addr;
      wr_data_ff <= nxt;
   end

   // Entry as it stands: the write of the previous cycle overtakes the RAM read.
   always_comb begin
      if (wr_valid_ff && (wr_addr_ff == s1_addr)) begin
         cur = wr_data_ff;
      end else if (written_ff[s1_addr]) begin
         cur = key_state_type'(rd_data);
      end else begin
         cur = KEY_STATE_RESET;
      end
   end

   always_comb begin
      nxt      = cur;
      f_down   = 1'b0;
      f_up     = 1'b0;
      f_rep    = 1'b0;
      f_single = 1'b0;
      f_lstart = 1'b0;
      f_lhold  = 1'b0;

      if ((cur.phase != PH_IDLE) && (cur.tick_count != TICK_MAX)) begin
         nxt.tick_count = cur.tick_count + 16'd1;
      end

      if (s1_pin_ff != cur.stable_level) begin
         if (cur.debounce_count < DEBOUNCE_MAX) begin
            nxt.debounce_count = cur.debounce_count + 3'd1;
         end
         if (nxt.debounce_count >= debounce_ff) begin
            nxt.stable_level   = s1_pin_ff;
            nxt.debounce_count = 3'd0;
         end
      end else begin
         nxt.debounce_count = 3'd0;
      end

      act = (nxt.stable_level == mask_ff[s1_key_ff]);

      case (cur.phase)
         PH_IDLE: begin
            if (act) begin
               nxt.last_event    = EV_DOWN;
               f_down            = 1'b1;
               nxt.tick_count    = 16'd0;
               nxt.press_repeats = 4'd1;
               nxt.phase         = PH_DOWN;
            end else begin
               nxt.last_event = EV_NONE;
            end
         end
         PH_DOWN: begin
            if (!act) begin
               nxt.last_event = EV_UP;
               f_up           = 1'b1;
               nxt.tick_count = 16'd0;
               nxt.phase      = PH_UP;
            end else if (nxt.tick_count > long_ff) begin
               nxt.last_event = EV_LSTART;
               f_lstart       = 1'b1;
               nxt.phase      = PH_LONG;
            end
         end
         PH_UP: begin
            if (act) begin
               nxt.last_event = EV_DOWN;
               f_down         = 1'b1;
               if (cur.press_repeats < REPEAT_MAX) begin
                  nxt.press_repeats = cur.press_repeats + 4'd1;
               end
               f_rep          = 1'b1;
               nxt.tick_count = 16'd0;
               nxt.phase      = PH_REPEAT;
            end else if (nxt.tick_count > short_ff) begin
               // Only a lone press ends as a single click.
               if (cur.press_repeats == 4'd1) begin
                  nxt.last_event = EV_SINGLE;
                  f_single       = 1'b1;
               end
               nxt.phase = PH_IDLE;
            end
         end
         PH_REPEAT: begin
            if (!act) begin
               nxt.last_event = EV_UP;
               f_up           = 1'b1;
               nxt.phase      = (nxt.tick_count < short_ff) ? PH_UP : PH_IDLE;
               nxt.tick_count = 16'd0;
            end else if (nxt.tick_count > short_ff) begin
               nxt.phase = PH_IDLE;
            end
         end
         PH_LONG: begin
            if (act) begin
               nxt.last_event = EV_LHOLD;
               f_lhold        = 1'b1;
            end else begin
               nxt.last_event = EV_UP;
               f_up           = 1'b1;
               nxt.phase      = PH_IDLE;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
   end

   // Output register.
   logic [2:0] key_id_ff;
   logic [2:0] event_code_ff;
   logic [3:0] repeat_count_ff;
   logic [5:0] fired_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         key_id_ff <= s1_key_ff;
         if (s1_in_range) begin
            event_code_ff   <= nxt.last_event;
            repeat_count_ff <= nxt.press_repeats;
            fired_ff        <= {f_lhold, f_lstart, f_single, f_rep, f_up, f_down};
         end else begin
            event_code_ff   <= EV_NONE;
            repeat_count_ff <= 4'd0;
            fired_ff        <= 6'd0;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.key_id           = key_id_ff;
   assign rsp_ch.event_code       = event_code_ff;
   assign rsp_ch.repeat_count     = repeat_count_ff;
   assign rsp_ch.fired_down       = fired_ff[0];
   assign rsp_ch.fired_up         = fired_ff[1];
   assign rsp_ch.fired_repeat     = fired_ff[2];
   assign rsp_ch.fired_single     = fired_ff[3];
   assign rsp_ch.fired_long_start = fired_ff[4];
   assign rsp_ch.fired_long_hold  = fired_ff[5];

endmodule

`default_nettype wire

### test/button_click_event_detector_tb.sv
// Self-checking testbench for the per-key button click and long-press detector.
`default_nettype none

module button_click_event_detector_tb;
   import bce_pkg::*;

   localparam longint RUN_LIMIT   = 64'd10_000_000;
   localparam int     HOLD_CYCLES = 100;

   // One event word as the block reports it.
   typedef struct packed {
      logic [2:0]  key_id;
      event_type   event_code;
      logic [3:0]  repeat_count;
      logic        fired_down;
      logic        fired_up;
      logic        fired_repeat;
      logic        fired_single;
      logic        fired_long_start;
      logic        fired_long_hold;
   } click_word_type;

   // Flags run {down, up, repeat, single, long start, long hold}.
   typedef struct packed {
      logic [2:0]  key;
      logic        pin;
      logic        typed;
      event_type   ev;
      logic [3:0]  reps;
      logic [5:0]  fired;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [15:0]            csr_wdata;

   bce_req_if req_ch ();
   bce_rsp_if rsp_ch ();

   button_click_event_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers and of every key's state.
   logic [7:0]     cfg_mask;
   logic [2:0]     cfg_debounce;
   logic [15:0]    cfg_short_gap;
   logic [15:0]    cfg_long_hold;
   key_state_type  key_mem [NUM_KEYS];

   click_word_type event_words_due [$];
   logic           drive_level [NUM_KEYS];
   int             mismatch_count = 0;
   int             words_checked  = 0;
   int             samples_sent   = 0;
   int             settings_used  = 0;

   // Sender and receiver pacing.
   bit             tx_gaps_on = 1'b1;
   int             tx_burst_left = 0;
   int             holds_asked = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             pat_left = 0;
   logic [15:0]    rx_pattern = 16'hFFFF;

   // Directed samples, run with mask 8'h80, zero debounce, short gap 2, long hold 3.
   stim_row_type directed_rows [0:20] = '{
      '{3'd0, 1'b1, 1'b1, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b0, 1'b1, EV_DOWN, 4'd1, 6'b100000},
      '{3'd0, 1'b1, 1'b1, EV_UP,   4'd1, 6'b010000},
      '{3'd0, 1'b0, 1'b1, EV_DOWN, 4'd2, 6'b101000},
      '{3'd0, 1'b1, 1'b1, EV_UP,   4'd2, 6'b010000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b0, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd0, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b1, 1'b1, EV_DOWN, 4'd1, 6'b100000},
      '{3'd7, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b1, 1'b0, EV_NONE, 4'd0, 6'b000000},
      '{3'd7, 1'b0, 1'b0, EV_NONE, 4'd0, 6'b000000}
   };

   function automatic click_word_type qualify_sample(input logic [2:0] key, input logic pin);
      click_word_type w;
      key_state_type  s;
      logic           held;
      w = '0;
      w.key_id = key;
      s = key_mem[key];
      if (s.phase != PH_IDLE && s.tick_count != TICK_MAX)
         s.tick_count = s.tick_count + 16'd1;
      if (pin != s.stable_level) begin
         if (s.debounce_count < DEBOUNCE_MAX)
            s.debounce_count = s.debounce_count + 3'd1;
         if (s.debounce_count >= cfg_debounce) begin
            s.stable_level = pin;
            s.debounce_count = 3'd0;
         end
      end else begin
         s.debounce_count = 3'd0;
      end
      held = (s.stable_level == cfg_mask[key]);
      case (s.phase)
         PH_IDLE: begin
            if (held) begin
               s.last_event = EV_DOWN;
               w.fired_down = 1'b1;
               s.tick_count = 16'd0;
               s.press_repeats = 4'd1;
               s.phase = PH_DOWN;
            end else begin
               s.last_event = EV_NONE;
            end
         end
         PH_DOWN: begin
            if (!held) begin
               s.last_event = EV_UP;
               w.fired_up = 1'b1;
               s.tick_count = 16'd0;
               s.phase = PH_UP;
            end else if (s.tick_count > cfg_long_hold) begin
               s.last_event = EV_LSTART;
               w.fired_long_start = 1'b1;
               s.phase = PH_LONG;
            end
         end
         PH_UP: begin
            if (held) begin
               s.last_event = EV_DOWN;
               w.fired_down = 1'b1;
               if (s.press_repeats < REPEAT_MAX)
                  s.press_repeats = s.press_repeats + 4'd1;
               w.fired_repeat = 1'b1;
               s.tick_count = 16'd0;
               s.phase = PH_REPEAT;
            end else if (s.tick_count > cfg_short_gap) begin
               // A sequence of several presses leaves the event code as it was.
               if (s.press_repeats == 4'd1) begin
                  s.last_event = EV_SINGLE;
                  w.fired_single = 1'b1;
               end
               s.phase = PH_IDLE;
            end
         end
         PH_REPEAT: begin
            if (!held) begin
               s.last_event = EV_UP;
               w.fired_up = 1'b1;
               // The count is compared before it is cleared.
               s.phase = (s.tick_count < cfg_short_gap) ? PH_UP : PH_IDLE;
               s.tick_count = 16'd0;
            end else if (s.tick_count > cfg_short_gap) begin
               s.phase = PH_IDLE;
            end
         end
         PH_LONG: begin
            if (held) begin
               s.last_event = EV_LHOLD;
               w.fired_long_hold = 1'b1;
            end else begin
               s.last_event = EV_UP;
               w.fired_up = 1'b1;
               s.phase = PH_IDLE;
            end
         end
         default: s.phase = PH_IDLE;
      endcase
      w.event_code = s.last_event;
      w.repeat_count = s.press_repeats;
      key_mem[key] = s;
      return w;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s", $time, msg);
   endtask

   // Offers one sample and waits until the block takes it.
   task automatic offer_sample(input logic [2:0] key, input logic pin,
                               input logic typed, input click_word_type typed_word);
      int             gap;
      click_word_type predicted;
      if (tx_gaps_on && tx_burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         tx_burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (tx_burst_left > 0)
         tx_burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.key_index <= key;
      req_ch.raw_level <= pin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      samples_sent++;
      predicted = qualify_sample(key, pin);
      event_words_due.push_back(typed ? typed_word : predicted);
   endtask

   task automatic wait_for_words();
      req_ch.valid <= 1'b0;
      while (event_words_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] mask, input logic [2:0] debounce,
                                input logic [15:0] short_gap, input logic [15:0] long_hold);
      csr_we <= 1'b1;
      csr_index <= CSR_ACTIVE_MASK;
      csr_wdata <= {8'd0, mask};
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= {13'd0, debounce};
      @(posedge clock);
      csr_index <= CSR_SHORT;
      csr_wdata <= short_gap;
      @(posedge clock);
      csr_index <= CSR_LONG;
      csr_wdata <= long_hold;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mask = mask;
      cfg_debounce = debounce;
      cfg_short_gap = short_gap;
      cfg_long_hold = long_hold;
      settings_used++;
   endtask

   // Presses and releases of random keys, with run lengths chosen around the
   // debounce, gap and hold thresholds, odd bounces and other keys mixed in.
   task automatic random_phase(input int items);
      int          done;
      int          n;
      int          lim_short;
      int          lim_long;
      logic [2:0]  key;
      logic        lvl;
      done = 0;
      lim_short = (cfg_short_gap > 24) ? 24 : int'(cfg_short_gap);
      lim_long = (cfg_long_hold > 48) ? 48 : int'(cfg_long_hold);
      while (done < items) begin
         key = 3'($urandom_range(0, 7));
         lvl = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : ~drive_level[key];
         case ($urandom_range(0, 5))
            0: n = $urandom_range(1, int'(cfg_debounce) + 1);
            1, 2: n = $urandom_range(1, lim_short + 2);
            3: n = $urandom_range(lim_long, lim_long + 3);
            default: n = $urandom_range(1, 6);
         endcase
         drive_level[key] = lvl;
         repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
               offer_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'b0, '0);
               done++;
            end
            offer_sample(key, ($urandom_range(0, 15) == 0) ? ~lvl : lvl, 1'b0, '0);
            done++;
         end
      end
   endtask

   // Receiver: a long hold-off when asked, otherwise a stall pattern of its own.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
            pat_left = 48;
         end
         pat_left = pat_left - 1;
         rsp_ch.ready <= rx_pattern[pat_left % 16];
      end
   end

   always @(posedge clock) begin : word_check
      click_word_type got;
      click_word_type want;
      string          bad;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.key_id = rsp_ch.key_id;
         got.event_code = event_type'(rsp_ch.event_code);
         got.repeat_count = rsp_ch.repeat_count;
         got.fired_down = rsp_ch.fired_down;
         got.fired_up = rsp_ch.fired_up;
         got.fired_repeat = rsp_ch.fired_repeat;
         got.fired_single = rsp_ch.fired_single;
         got.fired_long_start = rsp_ch.fired_long_start;
         got.fired_long_hold = rsp_ch.fired_long_hold;
         if (event_words_due.size() == 0) begin
            note_failure($sformatf("word with nothing awaited: %p", got));
         end else begin
            want = event_words_due.pop_front();
            words_checked++;
            bad = "";
            if (got.key_id !== want.key_id) bad = {bad, " key_id"};
            if (got.event_code !== want.event_code) bad = {bad, " event_code"};
            if (got.repeat_count !== want.repeat_count) bad = {bad, " repeat_count"};
            if (got.fired_down !== want.fired_down) bad = {bad, " fired_down"};
            if (got.fired_up !== want.fired_up) bad = {bad, " fired_up"};
            if (got.fired_repeat !== want.fired_repeat) bad = {bad, " fired_repeat"};
            if (got.fired_single !== want.fired_single) bad = {bad, " fired_single"};
            if (got.fired_long_start !== want.fired_long_start)
               bad = {bad, " fired_long_start"};
            if (got.fired_long_hold !== want.fired_long_hold) bad = {bad, " fired_long_hold"};
            if (bad != "")
               note_failure($sformatf("word %0d differs in%s: expected %p, got %p",
                                      words_checked, bad, want, got));
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      click_word_type typed_word;
      int             i;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.key_index = 3'd0;
      req_ch.raw_level = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ACTIVE_MASK;
      csr_wdata = 16'd0;
      cfg_mask = MASK_RESET;
      cfg_debounce = DEBOUNCE_RESET;
      cfg_short_gap = SHORT_RESET;
      cfg_long_hold = LONG_RESET;
      for (i = 0; i < NUM_KEYS; i++) begin
         key_mem[i] = KEY_STATE_RESET;
         key_mem[i].stable_level = ~MASK_RESET[i];
         drive_level[i] = ~MASK_RESET[i];
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Key 7 turns active-high while its settled level is high, so its first
      // sample reads as a press without any change on the pin.
      load_settings(8'h80, 3'd0, 16'd2, 16'd3);
      foreach (directed_rows[r]) begin
         typed_word = '0;
         typed_word.key_id = directed_rows[r].key;
         typed_word.event_code = directed_rows[r].ev;
         typed_word.repeat_count = directed_rows[r].reps;
         {typed_word.fired_down, typed_word.fired_up, typed_word.fired_repeat,
          typed_word.fired_single, typed_word.fired_long_start,
          typed_word.fired_long_hold} = directed_rows[r].fired;
         offer_sample(directed_rows[r].key, directed_rows[r].pin, directed_rows[r].typed,
                      typed_word);
      end
      wait_for_words();

      load_settings(8'h00, 3'd1, 16'd1, 16'd1);
      random_phase(300);
      wait_for_words();

      load_settings(8'hFF, 3'd7, 16'd65534, 16'd65534);
      random_phase(200);
      wait_for_words();

      // The receiver holds off while words keep coming, so the input side stalls.
      load_settings(8'hA5, 3'd2, 16'd12, 16'd30);
      random_phase(250);
      holds_asked++;
      tx_gaps_on = 1'b0;
      for (i = 0; i < 30; i++)
         offer_sample(3'(i), 1'($urandom_range(0, 1)), 1'b0, '0);
      tx_gaps_on = 1'b1;
      wait_for_words();
      random_phase(250);
      wait_for_words();

      load_settings(8'h3C, 3'd0, 16'd5, 16'd9);
      random_phase(400);
      wait_for_words();

      load_settings(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)),
                    16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)));
      random_phase(450);
      wait_for_words();
      repeat (8) @(posedge clock);

      $display("Run covered %0d samples and %0d event words over %0d register settings,",
               samples_sent, words_checked, settings_used);
      $display("with stalls on both sides and a long output hold-off.");
      if (mismatch_count == 0 && event_words_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
